[hdl/alle_pkg.sv]
// ----------------------------------------------------------------------------
// alle_pkg - shared constants for the array linked list engine
// Command and status codes, field widths and the default slot count.
// ----------------------------------------------------------------------------
package alle_pkg;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 4;

  // Default number of slots, head sentinel included
  localparam int SLOTS_DEFAULT = 16;

  // Request commands
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_BADPOS   = 3'd4;

endpackage

[hdl/array_linked_list_engine_top.sv]
// ----------------------------------------------------------------------------
// array_linked_list_engine_top - singly linked list held in a slot array
// Insert, delete, search and dump on a list whose links live in a memory.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid_i/in_ready_o with cmd_i, value_i, position_i
//   and place_after_i. Results leave on out_valid_o/out_ready_i; last_o marks
//   the final result of a request. Insert, delete and search give one result,
//   dump gives one result per element (one result on an empty list).
//   One request is worked on at a time; in_ready_o is high only while idle.
//   A single link/value memory read port does all list traversal, one link
//   per cycle, though a dump stops at each result until it is taken. Work per command:
//     insert : scan down from the top slot for a free slot, walk, link
//     delete : walk to position, unlink
//     search : compare elements in list order until a match or the end
//     dump   : step to each element, then hold its result until taken
//   Errors (full, empty, bad position) answer in the cycle after acceptance.
//   Reset leaves an empty list with every slot but the head free; no
//   clearing pass is needed. While the receiver stalls, the result is held
//   and the engine waits; no request is taken until all results are gone.
// ----------------------------------------------------------------------------
module array_linked_list_engine_top #(
  parameter int SLOTS = alle_pkg::SLOTS_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [alle_pkg::CMD_W-1:0]           cmd_i,
  input  logic signed [alle_pkg::VALUE_W-1:0]  value_i,
  input  logic [alle_pkg::POS_W-1:0]           position_i,
  input  logic                                 place_after_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [alle_pkg::STATUS_W-1:0]        status_o,
  output logic [alle_pkg::POS_W-1:0]           found_position_o,
  output logic signed [alle_pkg::VALUE_W-1:0]  element_value_o,
  output logic [alle_pkg::COUNT_W-1:0]         element_count_o,
  output logic                                 last_o
);

  localparam int IW = $clog2(SLOTS);
  localparam int XW = (IW > alle_pkg::POS_W) ? IW : alle_pkg::POS_W;
  localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FREE,
    ST_WALK,
    ST_INS_LINK,
    ST_DEL_LINK,
    ST_SRCH,
    ST_DUMP_STEP,
    ST_DUMP_EMIT,
    ST_RESP
  } state_e;

  // Sequencer state
  state_e state_q, state_d, ret_q, ret_d;
  logic [IW-1:0] cur_q, cur_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] steps_q, steps_d;
  logic [IW-1:0] fs_q, fs_d;
  logic [IW-1:0] prev_q, prev_d;
  logic          is_ins_q, is_ins_d;
  logic [alle_pkg::VALUE_W-1:0] value_q, value_d;

  // List state
  logic [IW-1:0]    count_q, count_d;
  logic [IW-1:0]    head_q, head_d;
  logic [SLOTS-1:0] free_q, free_d;

  // Result registers
  logic [alle_pkg::STATUS_W-1:0] res_status_q, res_status_d;
  logic [alle_pkg::POS_W-1:0]    res_pos_q, res_pos_d;
  logic [alle_pkg::VALUE_W-1:0]  res_value_q, res_value_d;
  logic [alle_pkg::COUNT_W-1:0]  res_count_q, res_count_d;
  logic                          res_last_q, res_last_d;

  // Link and value memories; slot 0 link is kept in head_q
  logic [IW-1:0]                link_mem [SLOTS];
  logic [alle_pkg::VALUE_W-1:0] value_mem [SLOTS];
  logic [IW-1:0]                mem_link_rd_q;
  logic [alle_pkg::VALUE_W-1:0] val_rd_q;
  logic                         rd_head_q;
  logic [IW-1:0]                link_rd;
  logic                         lw_en;
  logic [IW-1:0]                lw_addr, lw_data;
  logic                         vw_en;

  // Width helpers
  logic [XW-1:0] pos_x, cnt_x, steps_x;
  logic [XW-1:0] cnt_inc_x, cnt_dec_x, cnt_x4, idx_m1_x;
  logic [IW-1:0] idx_m1;
  logic          pos_bad;

  // link[cur_q] as seen by the walk, head entry bypassed from its register
  assign link_rd = rd_head_q ? head_q : mem_link_rd_q;

  assign pos_x     = XW'(position_i);
  assign cnt_x     = XW'(count_q);
  assign pos_bad   = (pos_x >= cnt_x);
  assign steps_x   = place_after_i ? (pos_x + XW'(1)) : pos_x;
  assign cnt_inc_x = XW'(count_q + IW'(1));
  assign cnt_dec_x = XW'(count_q - IW'(1));
  assign cnt_x4    = cnt_x;
  assign idx_m1    = idx_q - IW'(1);
  assign idx_m1_x  = XW'(idx_m1);

  assign in_ready_o       = (state_q == ST_IDLE);
  assign out_valid_o      = (state_q == ST_RESP);
  assign status_o         = res_status_q;
  assign found_position_o = res_pos_q;
  assign element_value_o  = res_value_q;
  assign element_count_o  = res_count_q;
  assign last_o           = res_last_q;

  // Sequencer next state
  always_comb begin
    state_d      = state_q;
    ret_d        = ret_q;
    cur_d        = cur_q;
    idx_d        = idx_q;
    steps_d      = steps_q;
    fs_d         = fs_q;
    prev_d       = prev_q;
    is_ins_d     = is_ins_q;
    value_d      = value_q;
    count_d      = count_q;
    head_d       = head_q;
    free_d       = free_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    res_value_d  = res_value_q;
    res_count_d  = res_count_q;
    res_last_d   = res_last_q;
    lw_en        = 1'b0;
    lw_addr      = prev_q;
    lw_data      = link_rd;
    vw_en        = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        cur_d = '0;
        idx_d = '0;
        if (in_valid_i) begin
          value_d      = value_i;
          res_pos_d    = '0;
          res_value_d  = '0;
          res_last_d   = 1'b1;
          res_count_d  = cnt_x4[alle_pkg::COUNT_W-1:0];
          res_status_d = alle_pkg::STATUS_OK;
          ret_d        = ST_IDLE;
          unique case (cmd_i)
            alle_pkg::CMD_INSERT: begin
              is_ins_d = 1'b1;
              if (count_q == LAST_SLOT) begin
                res_status_d = alle_pkg::STATUS_FULL;
                state_d      = ST_RESP;
              end else if (count_q != '0 && pos_bad) begin
                res_status_d = alle_pkg::STATUS_BADPOS;
                state_d      = ST_RESP;
              end else begin
                fs_d    = LAST_SLOT;
                steps_d = (count_q == '0) ? '0 : IW'(steps_x);
                state_d = ST_FREE;
              end
            end
            alle_pkg::CMD_DELETE: begin
              is_ins_d = 1'b0;
              if (count_q == '0) begin
                res_status_d = alle_pkg::STATUS_EMPTY;
                state_d      = ST_RESP;
              end else if (pos_bad) begin
                res_status_d = alle_pkg::STATUS_BADPOS;
                state_d      = ST_RESP;
              end else begin
                steps_d = IW'(pos_x);
                state_d = ST_WALK;
              end
            end
            default: begin
              if (count_q == '0) begin
                res_status_d = alle_pkg::STATUS_EMPTY;
                state_d      = ST_RESP;
              end else if (cmd_i == alle_pkg::CMD_SEARCH) begin
                state_d = ST_SRCH;
              end else begin
                state_d = ST_DUMP_STEP;
              end
            end
          endcase
        end
      end

      // Highest-numbered free slot, scanning down
      ST_FREE: begin
        if (free_q[fs_q]) begin
          state_d = ST_WALK;
        end else begin
          fs_d = fs_q - IW'(1);
        end
      end

      // Follow links from the head, one per cycle
      ST_WALK: begin
        if (idx_q == steps_q) begin
          prev_d = cur_q;
          if (is_ins_q) begin
            // new slot takes the old successor and the value
            lw_en   = 1'b1;
            lw_addr = fs_q;
            lw_data = link_rd;
            vw_en   = 1'b1;
            state_d = ST_INS_LINK;
          end else begin
            cur_d   = link_rd;
            state_d = ST_DEL_LINK;
          end
        end else begin
          cur_d = link_rd;
          idx_d = idx_q + IW'(1);
        end
      end

      // Predecessor points at the new slot
      ST_INS_LINK: begin
        if (prev_q == '0) begin
          head_d = fs_q;
        end else begin
          lw_en   = 1'b1;
          lw_addr = prev_q;
          lw_data = fs_q;
        end
        free_d[fs_q] = 1'b0;
        count_d      = count_q + IW'(1);
        res_count_d  = cnt_inc_x[alle_pkg::COUNT_W-1:0];
        cur_d        = '0;
        state_d      = ST_RESP;
      end

      // Predecessor skips the deleted slot
      ST_DEL_LINK: begin
        if (prev_q == '0) begin
          head_d = link_rd;
        end else begin
          lw_en   = 1'b1;
          lw_addr = prev_q;
          lw_data = link_rd;
        end
        free_d[cur_q] = 1'b1;
        count_d       = count_q - IW'(1);
        res_count_d   = cnt_dec_x[alle_pkg::COUNT_W-1:0];
        cur_d         = '0;
        state_d       = ST_RESP;
      end

      // Compare element idx-1, then step to the next one
      ST_SRCH: begin
        if (idx_q != '0 && val_rd_q == value_q) begin
          res_pos_d = idx_m1_x[alle_pkg::POS_W-1:0];
          cur_d     = '0;
          state_d   = ST_RESP;
        end else if (idx_q == count_q) begin
          res_status_d = alle_pkg::STATUS_NOTFOUND;
          cur_d        = '0;
          state_d      = ST_RESP;
        end else begin
          cur_d = link_rd;
          idx_d = idx_q + IW'(1);
        end
      end

      ST_DUMP_STEP: begin
        cur_d   = link_rd;
        idx_d   = idx_q + IW'(1);
        state_d = ST_DUMP_EMIT;
      end

      ST_DUMP_EMIT: begin
        res_status_d = alle_pkg::STATUS_OK;
        res_pos_d    = idx_m1_x[alle_pkg::POS_W-1:0];
        res_value_d  = val_rd_q;
        res_last_d   = (idx_q == count_q);
        if (idx_q == count_q) begin
          ret_d = ST_IDLE;
          cur_d = '0;
        end else begin
          ret_d = ST_DUMP_STEP;
        end
        state_d = ST_RESP;
      end

      ST_RESP: begin
        if (out_ready_i) begin
          state_d = ret_q;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ret_q        <= ST_IDLE;
      cur_q        <= '0;
      idx_q        <= '0;
      steps_q      <= '0;
      fs_q         <= '0;
      prev_q       <= '0;
      is_ins_q     <= 1'b0;
      count_q      <= '0;
      head_q       <= '0;
      free_q       <= {{(SLOTS-1){1'b1}}, 1'b0};
      rd_head_q    <= 1'b1;
      res_status_q <= alle_pkg::STATUS_OK;
      res_pos_q    <= '0;
      res_count_q  <= '0;
      res_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      ret_q        <= ret_d;
      cur_q        <= cur_d;
      idx_q        <= idx_d;
      steps_q      <= steps_d;
      fs_q         <= fs_d;
      prev_q       <= prev_d;
      is_ins_q     <= is_ins_d;
      count_q      <= count_d;
      head_q       <= head_d;
      free_q       <= free_d;
      rd_head_q    <= (cur_d == '0);
      res_status_q <= res_status_d;
      res_pos_q    <= res_pos_d;
      res_count_q  <= res_count_d;
      res_last_q   <= res_last_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    value_q     <= value_d;
    res_value_q <= res_value_d;
  end

  // Memories: one link write, one value write, registered read at the next walk slot
  always_ff @(posedge clk_i) begin
    if (lw_en) begin
      link_mem[lw_addr] <= lw_data;
    end
    if (vw_en) begin
      value_mem[fs_q] <= value_q;
    end
    mem_link_rd_q <= link_mem[cur_d];
    val_rd_q      <= value_mem[cur_d];
  end

endmodule
